// ----- hdl/stti_pkg.sv -----
// shared constants, codes and types of the time table interpolator
package stti_pkg;

    localparam int DATA_W         = 32;
    localparam int MAX_POINTS_DEF = 64;
    localparam int FRAC_W         = 16;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // operands handed to the interpolation unit
    typedef struct packed {
        logic                     start;
        logic signed [DATA_W-1:0] t;
        logic signed [DATA_W-1:0] t0;
        logic signed [DATA_W-1:0] t1;
        logic signed [DATA_W-1:0] v0;
        logic signed [DATA_W-1:0] v1;
    } interp_req_t;

    // completion back from the interpolation unit
    typedef struct packed {
        logic                     done;
        logic signed [DATA_W-1:0] value;
    } interp_rsp_t;

endpackage

// ----- hdl/stti_ram.sv -----
// generic simple dual-port ram with registered read
module stti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/stti_interp.sv -----
// iterative interpolation unit: one shared adder runs divide, multiply and final add
module stti_interp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  stti_pkg::interp_req_t req,
    output stti_pkg::interp_rsp_t rsp
);

    localparam int DW  = stti_pkg::DATA_W;
    localparam int FW  = stti_pkg::FRAC_W;
    localparam int AW  = DW + 3;
    localparam int CW  = $clog2(FW);

    typedef enum logic [3:0] {
        A_IDLE = 4'b0001,
        A_DIV  = 4'b0010,
        A_MUL  = 4'b0100,
        A_ADD  = 4'b1000
    } astate_t;

    astate_t          state_reg, state_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [DW:0]      rem_reg, rem_next;
    logic [DW:0]      den_reg, den_next;
    logic [DW:0]      mag_reg, mag_next;
    logic             neg_reg, neg_next;
    logic [FW-1:0]    quo_reg, quo_next;
    logic [DW+1:0]    hi_reg, hi_next;
    logic [DW-1:0]    v0_reg, v0_next;
    logic [DW-1:0]    res_reg, res_next;
    logic             done_reg, done_next;

    // shared adder / subtractor
    logic [AW-1:0] add_a, add_b, add_sum;
    logic          add_sub;

    logic signed [DW:0] delta;

    assign add_sum = add_a + (add_sub ? ~add_b : add_b) + AW'(add_sub);
    assign delta   = DW'(0) + ({req.v1[DW-1], req.v1} - {req.v0[DW-1], req.v0});

    always_comb
    begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        case (state_reg)
            A_DIV:
            begin
                add_a   = AW'({rem_reg, 1'b0});
                add_b   = AW'(den_reg);
                add_sub = 1'b1;
            end
            A_MUL:
            begin
                add_a = AW'(hi_reg);
                add_b = quo_reg[0] ? AW'(mag_reg) : '0;
            end
            A_ADD:
            begin
                add_a   = {{(AW-DW){v0_reg[DW-1]}}, v0_reg};
                add_b   = AW'(hi_reg);
                add_sub = neg_reg;
            end
            default:
            begin
                add_a = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        quo_next   = quo_reg;
        hi_next    = hi_reg;
        v0_next    = v0_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    // exact 33-bit differences, all positive but the value delta
                    rem_next   = {req.t[DW-1], req.t} - {req.t0[DW-1], req.t0};
                    den_next   = {req.t1[DW-1], req.t1} - {req.t0[DW-1], req.t0};
                    neg_next   = delta[DW];
                    mag_next   = delta[DW] ? (DW+1)'(-delta) : delta;
                    v0_next    = req.v0;
                    cnt_next   = '0;
                    state_next = A_DIV;
                end
            end
            A_DIV:
            begin
                // restoring divide, one quotient bit a step
                if (!add_sum[AW-1])
                begin
                    rem_next = add_sum[DW:0];
                end
                else
                begin
                    rem_next = {rem_reg[DW-1:0], 1'b0};
                end
                quo_next = {quo_reg[FW-2:0], ~add_sum[AW-1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(FW - 1))
                begin
                    hi_next    = '0;
                    state_next = A_MUL;
                end
            end
            A_MUL:
            begin
                // shift-add multiply, the low product bits fall off the right
                hi_next  = add_sum[DW+2:1];
                quo_next = {1'b0, quo_reg[FW-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(FW - 1))
                begin
                    state_next = A_ADD;
                end
            end
            A_ADD:
            begin
                res_next   = add_sum[DW-1:0];
                done_next  = 1'b1;
                state_next = A_IDLE;
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        hi_reg  <= hi_next;
        v0_reg  <= v0_next;
        res_reg <= res_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.value = res_reg;

endmodule

// ----- hdl/scalar_time_table_interpolator_top.sv -----
// top level of the piecewise-linear time table interpolator
//
// usage
//   input channel (in_valid/in_ready) carries one word: operation, sample_time,
//   point_value. a load inserts a breakpoint at its sorted place (or overwrites
//   the value of an equal time); a query returns the table value at sample_time.
//   output channel (out_valid/out_ready) returns one word per input: status and
//   scaled_value. in_ready is high only while the sequencer is idle.
// sequence, with n stored points and p the first entry not below the time
//   search: a read then a compare on the ram port per entry visited, up to
//   n entries. a load then moves n-p entries, each read then written, plus
//   an insert step. an interpolating query runs the shared divide/multiply
//   unit (16 divide steps, 16 multiply steps, final add). a finish step hands
//   the result to the output register.
// rate: one word at a time; the next word is taken once the previous result
//   sits in the output register.
// reset clears the point count and all valid flags; the ram contents are not
//   cleared and are only read below the point count.
// a stalled receiver holds the output register; a finished result then waits
//   in the sequencer until the output register frees up.
module scalar_time_table_interpolator_top #(
    parameter int MAX_POINTS = stti_pkg::MAX_POINTS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               operation,
    input  logic signed [stti_pkg::DATA_W-1:0] sample_time,
    input  logic signed [stti_pkg::DATA_W-1:0] point_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [1:0]                         status,
    output logic signed [stti_pkg::DATA_W-1:0] scaled_value
);

    localparam int DW    = stti_pkg::DATA_W;
    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_SCAN_RD  = 9'b000000010,
        S_SCAN_CMP = 9'b000000100,
        S_SH_RD    = 9'b000001000,
        S_SH_WR    = 9'b000010000,
        S_INS      = 9'b000100000,
        S_UPD      = 9'b001000000,
        S_INTERP   = 9'b010000000,
        S_FINISH   = 9'b100000000
    } state_t;

    // control state
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              out_valid_reg, out_valid_next;

    // working and payload registers
    logic              op_reg, op_next;
    logic signed [DW-1:0] t_reg, t_next;
    logic signed [DW-1:0] v_reg, v_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    logic signed [DW-1:0] prev_t_reg, prev_t_next;
    logic signed [DW-1:0] prev_v_reg, prev_v_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic signed [DW-1:0] res_value_reg, res_value_next;
    logic [1:0]        out_status_reg, out_status_next;
    logic signed [DW-1:0] out_value_reg, out_value_next;

    // ram ports, both stores share addresses
    logic              t_we, v_we;
    logic [IDX_W-1:0]  waddr, raddr;
    logic [DW-1:0]     t_wdata, v_wdata, t_rdata, v_rdata;
    logic signed [DW-1:0] t_rd, v_rd;

    stti_pkg::interp_req_t ireq;
    stti_pkg::interp_rsp_t irsp;

    logic in_acc;
    logic out_free;
    logic lt;

    assign t_rd     = $signed(t_rdata);
    assign v_rd     = $signed(v_rdata);
    assign in_ready = (state_reg == S_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign lt       = (t_rd < t_reg);

    stti_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_POINTS)
    ) u_time_ram (
        .clk   (clk),
        .we    (t_we),
        .waddr (waddr),
        .wdata (t_wdata),
        .raddr (raddr),
        .rdata (t_rdata)
    );

    stti_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_POINTS)
    ) u_value_ram (
        .clk   (clk),
        .we    (v_we),
        .waddr (waddr),
        .wdata (v_wdata),
        .raddr (raddr),
        .rdata (v_rdata)
    );

    stti_interp u_interp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ireq),
        .rsp   (irsp)
    );

    // ram port steering
    always_comb
    begin
        t_we    = 1'b0;
        v_we    = 1'b0;
        waddr   = pos_reg;
        raddr   = idx_reg;
        t_wdata = t_reg;
        v_wdata = v_reg;
        case (state_reg)
            S_SH_RD:
            begin
                raddr = k_reg - 1'b1;
            end
            S_SH_WR:
            begin
                // move entry k-1 up to k
                t_we    = 1'b1;
                v_we    = 1'b1;
                waddr   = k_reg;
                t_wdata = t_rdata;
                v_wdata = v_rdata;
            end
            S_INS:
            begin
                t_we = 1'b1;
                v_we = 1'b1;
            end
            S_UPD:
            begin
                v_we = 1'b1;
            end
            default:
            begin
                raddr = idx_reg;
            end
        endcase
    end

    // operands for the interpolation unit come straight off the compare cycle
    always_comb
    begin
        ireq.t     = t_reg;
        ireq.t0    = prev_t_reg;
        ireq.t1    = t_rd;
        ireq.v0    = prev_v_reg;
        ireq.v1    = v_rd;
        ireq.start = (state_reg == S_SCAN_CMP) && (op_reg == stti_pkg::OP_QUERY)
                     && !lt && (t_rd != t_reg) && (idx_reg != '0);
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        op_next         = op_reg;
        t_next          = t_reg;
        v_next          = v_reg;
        idx_next        = idx_reg;
        k_next          = k_reg;
        pos_next        = pos_reg;
        prev_t_next     = prev_t_reg;
        prev_v_next     = prev_v_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    op_next         = operation;
                    t_next          = sample_time;
                    v_next          = point_value;
                    idx_next        = '0;
                    pos_next        = '0;
                    res_status_next = stti_pkg::ST_OK;
                    res_value_next  = '0;
                    if (count_reg == '0)
                    begin
                        if (operation == stti_pkg::OP_QUERY)
                        begin
                            res_status_next = stti_pkg::ST_EMPTY;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_INS;
                        end
                    end
                    else
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                prev_t_next = t_rd;
                prev_v_next = v_rd;
                if (lt && (CNT_W'(idx_reg) != count_reg - 1'b1))
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
                else if (op_reg == stti_pkg::OP_LOAD)
                begin
                    pos_next = lt ? count_reg[IDX_W-1:0] : idx_reg;
                    k_next   = count_reg[IDX_W-1:0];
                    if (!lt && (t_rd == t_reg))
                    begin
                        state_next = S_UPD;
                    end
                    else if (count_reg == CNT_W'(MAX_POINTS))
                    begin
                        res_status_next = stti_pkg::ST_FULL;
                        state_next      = S_FINISH;
                    end
                    else if (lt)
                    begin
                        // append past the last entry, nothing to move
                        state_next = S_INS;
                    end
                    else
                    begin
                        state_next = S_SH_RD;
                    end
                end
                else if (ireq.start)
                begin
                    state_next = S_INTERP;
                end
                else
                begin
                    // exact match, above the last or below the first point
                    res_value_next = v_rd;
                    state_next     = S_FINISH;
                end
            end
            S_SH_RD:
            begin
                state_next = S_SH_WR;
            end
            S_SH_WR:
            begin
                k_next = k_reg - 1'b1;
                if ((k_reg - 1'b1) > pos_reg)
                begin
                    state_next = S_SH_RD;
                end
                else
                begin
                    state_next = S_INS;
                end
            end
            S_INS:
            begin
                count_next = count_reg + 1'b1;
                state_next = S_FINISH;
            end
            S_UPD:
            begin
                state_next = S_FINISH;
            end
            S_INTERP:
            begin
                if (irsp.done)
                begin
                    res_value_next = irsp.value;
                    state_next     = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if ((state_reg == S_FINISH) && out_free)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_value_next  = res_value_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        t_reg          <= t_next;
        v_reg          <= v_next;
        idx_reg        <= idx_next;
        k_reg          <= k_next;
        pos_reg        <= pos_next;
        prev_t_reg     <= prev_t_next;
        prev_v_reg     <= prev_v_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign scaled_value = out_value_reg;

endmodule

// ----- test/scalar_time_table_interpolator_top_tb.sv -----
// self-checking testbench for the piecewise-linear time table interpolator
module scalar_time_table_interpolator_top_tb;

    localparam int TABLE_DEPTH = stti_pkg::MAX_POINTS_DEF;
    // margin after the last answer, so this covers any tail
    localparam int DRAIN_CYCLES = 4 * TABLE_DEPTH + 80;

    // one expected result word
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] value;
    } answer_t;

    logic                                clk          = 1'b0;
    logic                                rst_n        = 1'b0;
    logic                                in_valid     = 1'b0;
    logic                                in_ready;
    logic                                operation    = stti_pkg::OP_LOAD;
    logic signed [stti_pkg::DATA_W-1:0]  sample_time  = '0;
    logic signed [stti_pkg::DATA_W-1:0]  point_value  = '0;
    logic                                out_valid;
    logic                                out_ready    = 1'b0;
    logic [1:0]                          status;
    logic signed [stti_pkg::DATA_W-1:0]  scaled_value;

    // breakpoint table as the testbench sees it, updated at each accepted word
    logic signed [31:0] bp_time  [TABLE_DEPTH];
    logic signed [31:0] bp_value [TABLE_DEPTH];
    int                 bp_count = 0;

    answer_t awaited_answers[$];
    int      mismatches   = 0;
    bit      idle_en      = 1'b1;
    int      rx_hold_req  = 0;
    int      rx_hold_left = 0;
    int      rx_gap_left  = 0;

    scalar_time_table_interpolator_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .sample_time  (sample_time),
        .point_value  (point_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .scaled_value (scaled_value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [31:0] q16(input int whole);
        return 32'(whole * 65536);
    endfunction

    // answer of the table to one word; loads also update the table
    function automatic answer_t predict_table_answer(input logic op,
                                                     input logic signed [31:0] t,
                                                     input logic signed [31:0] v);
        answer_t         ans;
        int              pos;
        int              k;
        longint          t0, t1, v0, v1, dlt, stp;
        logic [63:0]     num, den, frac, mag, stepm;
        ans.status = stti_pkg::ST_OK;
        ans.value  = '0;
        pos = 0;
        while (pos < bp_count && bp_time[pos] < t)
            pos++;
        if (op == stti_pkg::OP_LOAD)
        begin
            if (pos < bp_count && bp_time[pos] == t)
                bp_value[pos] = v;
            else if (bp_count >= TABLE_DEPTH)
                ans.status = stti_pkg::ST_FULL;
            else
            begin
                for (k = bp_count; k > pos; k--)
                begin
                    bp_time[k]  = bp_time[k-1];
                    bp_value[k] = bp_value[k-1];
                end
                bp_time[pos]  = t;
                bp_value[pos] = v;
                bp_count++;
            end
        end
        else if (bp_count == 0)
            ans.status = stti_pkg::ST_EMPTY;
        else if (pos < bp_count && bp_time[pos] == t)
            ans.value = bp_value[pos];
        else if (pos >= bp_count)
            ans.value = bp_value[bp_count-1];
        else if (pos == 0)
            ans.value = bp_value[0];
        else
        begin
            // fraction from exact 33-bit differences, then truncated magnitude step
            t0    = bp_time[pos-1];
            t1    = bp_time[pos];
            v0    = bp_value[pos-1];
            v1    = bp_value[pos];
            num   = longint'(t) - t0;
            num   = num << 16;
            den   = t1 - t0;
            frac  = num / den;
            dlt   = v1 - v0;
            mag   = (dlt < 0) ? -dlt : dlt;
            stepm = (frac * mag) >> 16;
            stp   = (dlt < 0) ? -longint'(stepm) : longint'(stepm);
            ans.value = 32'(v0 + stp);
        end
        return ans;
    endfunction

    // offer one word and wait for it to be taken; valid stays up for the next word
    task automatic send_word(input logic op, input logic signed [31:0] t,
                             input logic signed [31:0] v);
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        sample_time <= t;
        point_value <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        awaited_answers.push_back(predict_table_answer(op, t, v));
    endtask

    // drop valid and wait until every expected result word has come back
    task automatic wait_all_answered();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_answers.size() != 0);
    endtask

    // queries on an empty table, ignored value field all ones and all zeros
    task automatic test_empty_table();
        send_word(stti_pkg::OP_QUERY, 32'sh0000_0000, 32'hFFFF_FFFF);
        send_word(stti_pkg::OP_QUERY, 32'sh8000_0000, 32'h0000_0000);
        send_word(stti_pkg::OP_QUERY, 32'sh7FFF_FFFF, 32'h5A5A_A5A5);
    endtask

    // exact hit, both ends, interpolation up and down, overwrite, extreme spans
    task automatic test_edges_and_overwrite();
        send_word(stti_pkg::OP_LOAD,  q16(5),  q16(100));
        send_word(stti_pkg::OP_QUERY, q16(5),  32'hFFFF_FFFF);
        send_word(stti_pkg::OP_QUERY, q16(0),  '0);
        send_word(stti_pkg::OP_QUERY, q16(10), '0);
        send_word(stti_pkg::OP_LOAD,  q16(10), q16(-50));
        send_word(stti_pkg::OP_QUERY, q16(7) + 32'sh8000, '0);
        send_word(stti_pkg::OP_QUERY, q16(5) + 1, '0);
        send_word(stti_pkg::OP_LOAD,  q16(10), q16(200));
        send_word(stti_pkg::OP_QUERY, q16(10) - 1, '0);
        send_word(stti_pkg::OP_QUERY, q16(12), '0);
        send_word(stti_pkg::OP_LOAD,  32'sh8000_0000, 32'sh7FFF_FFFF);
        send_word(stti_pkg::OP_QUERY, 32'sh8000_0001, '0);
        send_word(stti_pkg::OP_QUERY, q16(4), '0);
        send_word(stti_pkg::OP_LOAD,  32'sh7FFF_FFFF, 32'sh8000_0000);
        send_word(stti_pkg::OP_QUERY, 32'sh7FFF_FFFE, '0);
        send_word(stti_pkg::OP_QUERY, q16(11), '0);
        send_word(stti_pkg::OP_QUERY, 32'sh8000_0000, '0);
        send_word(stti_pkg::OP_QUERY, 32'sh7FFF_FFFF, '0);
    endtask

    // receiver stalls long while words keep coming, then the sender waits for all
    task automatic test_back_pressure();
        rx_hold_req = 300;
        repeat (12)
            send_word($urandom_range(0, 1) ? stti_pkg::OP_QUERY : stti_pkg::OP_LOAD,
                      $urandom, $urandom);
        wait_all_answered();
        repeat (6)
            send_word(stti_pkg::OP_QUERY, $urandom, $urandom);
    endtask

    // mixed loads and queries with random content
    task automatic test_random_traffic(input int n_words);
        logic               op;
        logic signed [31:0] t;
        logic signed [31:0] v;
        repeat (n_words)
        begin
            op = ($urandom_range(0, 99) < ((bp_count < TABLE_DEPTH) ? 50 : 30))
                 ? stti_pkg::OP_LOAD : stti_pkg::OP_QUERY;
            if (bp_count != 0 && $urandom_range(0, 3) == 0)
            begin
                t = bp_time[$urandom_range(0, bp_count - 1)];
                if (op == stti_pkg::OP_QUERY && $urandom_range(0, 1) == 1)
                    t = t + $urandom_range(0, 6) - 3;
            end
            else if ($urandom_range(0, 2) == 0)
                t = q16(int'($urandom_range(0, 40)) - 20)
                    + ($urandom_range(0, 1) ? $urandom_range(0, 65535) : 0);
            else
                t = $urandom;
            if ($urandom_range(0, 2) == 0)
                v = q16(int'($urandom_range(0, 200)) - 100);
            else
                v = $urandom;
            send_word(op, t, v);
        end
    endtask

    // fill to the last slot, then a new time is dropped and a known one overwritten
    task automatic test_table_full();
        logic signed [31:0] t;
        bit                 hit;
        int                 k;
        while (bp_count < TABLE_DEPTH)
            send_word(stti_pkg::OP_LOAD, $urandom, $urandom);
        do
        begin
            t   = $urandom;
            hit = 1'b0;
            for (k = 0; k < bp_count; k++)
                if (bp_time[k] == t)
                    hit = 1'b1;
        end
        while (hit);
        send_word(stti_pkg::OP_LOAD, t, $urandom);
        send_word(stti_pkg::OP_LOAD, bp_time[$urandom_range(0, TABLE_DEPTH - 1)], $urandom);
        send_word(stti_pkg::OP_QUERY, t, '0);
    endtask

    // receiver ready: long hold on request, short random bursts otherwise
    always @(posedge clk)
    begin : rx_ready_drive
        if (rx_hold_req > 0)
        begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            out_ready <= 1'b0;
        end
        else if (rx_gap_left > 0)
        begin
            rx_gap_left--;
            out_ready <= 1'b0;
        end
        else if (idle_en && $urandom_range(0, 4) == 0)
        begin
            rx_gap_left = $urandom_range(1, 3) - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // compare every result word with the oldest expectation
    always @(posedge clk)
    begin : rx_check
        answer_t exp_ans;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: status %0d value %h",
                             status, scaled_value);
            end
            else
            begin
                exp_ans = awaited_answers.pop_front();
                if (status !== exp_ans.status || scaled_value !== exp_ans.value)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: status exp %0d got %0d, value exp %h got %h",
                                 exp_ans.status, status, exp_ans.value, scaled_value);
                end
            end
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_table();
        test_edges_and_overwrite();
        test_back_pressure();
        test_random_traffic(400);
        test_table_full();
        test_random_traffic(800);
        // steady stream with no idling on either side
        idle_en = 1'b0;
        test_random_traffic(300);
        wait_all_answered();
        repeat (DRAIN_CYCLES) @(posedge clk);
        mismatches += awaited_answers.size();
        if (mismatches == 0)
            $display("scalar_time_table_interpolator_top_tb: done, clean");
        else
            $display("scalar_time_table_interpolator_top_tb: done, errors");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("scalar_time_table_interpolator_top_tb: done, errors");
        $finish;
    end

endmodule
